### hdl/keq_pkg.sv
// Shared constants, types and the usage-to-key table of the key edge event queue.
`default_nettype none

package keq_pkg;

   // Ring queue and held-bitmap sizes.
   localparam int QUEUE_DEPTH  = 64;
   localparam int BITMAP_WORDS = 8;
   localparam int PTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int WORD_SEL_W   = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;

   // Fixed field widths.
   localparam int WORD_W = 3;
   localparam int LANES  = 32;
   localparam int LANE_W = 5;
   localparam int KEY_W  = 8;

   // Operation codes of a request word.
   typedef enum logic {
      OP_SNAPSHOT = 1'b0,
      OP_POP      = 1'b1
   } op_type;

   // What one lane reports about its bit of the changed mask.
   typedef struct packed {
      logic             hit;
      logic             pressed;
      logic [KEY_W-1:0] key_code;
   } lane_hit_type;

   // Maps a HID usage to a game key code; zero means the usage is not mapped.
   function automatic logic [KEY_W-1:0] usage_to_key(input logic [7:0] usage);
      logic [KEY_W-1:0] key;
      unique case (usage)
         8'h52, 8'h1a: key = 8'had;
         8'h51, 8'h16: key = 8'haf;
         8'h50:        key = 8'hac;
         8'h4f:        key = 8'hae;
         8'h04:        key = 8'ha0;
         8'h07:        key = 8'ha1;
         8'h2c:        key = 8'ha2;
         8'he0, 8'he4: key = 8'ha3;
         8'he1, 8'he5: key = 8'hb6;
         8'h28:        key = 8'h0d;
         8'h29:        key = 8'h1b;
         8'h2b:        key = 8'h09;
         8'h1e:        key = 8'h31;
         8'h1f:        key = 8'h32;
         8'h20:        key = 8'h33;
         8'h21:        key = 8'h34;
         8'h22:        key = 8'h35;
         8'h23:        key = 8'h36;
         8'h24:        key = 8'h37;
         default:      key = '0;
      endcase
      return key;
   endfunction

endpackage

`default_nettype wire

### hdl/keq_ifs.sv
// Valid/ready channel interfaces for the request and response words.
`default_nettype none

interface keq_req_if import keq_pkg::*; ();
   logic              valid;
   logic              ready;
   op_type            op;
   logic [WORD_W-1:0] word_index;
   logic [31:0]       held_bits;

   modport source (output valid, output op, output word_index, output held_bits,
                   input ready);
   modport sink   (input valid, input op, input word_index, input held_bits,
                   output ready);
endinterface

interface keq_rsp_if import keq_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             event_valid;
   logic             pressed;
   logic [KEY_W-1:0] key_code;

   modport source (output valid, output event_valid, output pressed, output key_code,
                   input ready);
   modport sink   (input valid, input event_valid, input pressed, input key_code,
                   output ready);
endinterface

`default_nettype wire

### hdl/keq_lane.sv
// One bit lane: maps its usage through the key table and flags a mapped change.
`default_nettype none

module keq_lane import keq_pkg::*; (
   input  wire logic [WORD_W-1:0] word_sel,
   input  wire logic [LANE_W-1:0] lane_index,
   input  wire logic              changed,
   input  wire logic              now_bit,
   output lane_hit_type           lane_out
);

   logic [KEY_W-1:0] key;

   // The usage is the word number followed by the bit number.
   assign key = usage_to_key({word_sel, lane_index});

   assign lane_out.hit      = changed && (key != '0);
   assign lane_out.pressed  = now_bit;
   assign lane_out.key_code = key;

endmodule

`default_nettype wire

### hdl/keq_merge.sv
// Merging stage: picks the lowest lane that reports a mapped change.
`default_nettype none

module keq_merge import keq_pkg::*; (
   input  lane_hit_type           lanes [LANES],
   output lane_hit_type           pick,
   output logic [LANES-1:0]       pick_mask
);

   logic [LANES-1:0] hits;

   // Collect the hit flags of all lanes.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         hits[i] = lanes[i].hit;
      end
   end

   // Isolate the lowest set hit.
   assign pick_mask = hits & (~hits + 1'b1);

   // Select the chosen lane's event; all zero when no lane hits.
   always_comb begin
      pick = '0;
      for (int i = 0; i < LANES; i++) begin
         if (pick_mask[i]) begin
            pick = lanes[i];
         end
      end
   end

endmodule

`default_nettype wire

### hdl/key_edge_event_queue_core.sv
// Top level: held-bitmap edge detection over 32 lanes feeding a ring event queue.
//
//   channel   direction   word contents
//   req       in          op, word_index, held_bits
//   rsp       out         event_valid, pressed, key_code
//
// A pop's response is registered and shows on the next cycle.
// A snapshot walks the mapped usages that changed in its word (at most 32): the merge
// stage pushes one event into the queue memory per cycle, dropping it while it is full.
// Reset clears the held bitmap and both queue pointers; queue entries are not cleared.
// No word is accepted during a snapshot walk, nor while a response waits unless
// it is being taken in the same cycle.
`default_nettype none

module key_edge_event_queue_core import keq_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   keq_req_if.sink  req,
   keq_rsp_if.source rsp
);

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   state_type         state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [LANES-1:0]  pend_ff, pend_in;
   logic [LANES-1:0]  now_ff, now_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [31:0]       prev_ff [BITMAP_WORDS];
   logic [31:0]       prev_in [BITMAP_WORDS];

   logic [KEY_W:0]    event_store [QUEUE_DEPTH];
   logic              rsp_event_valid_ff;
   logic              rsp_pressed_ff;
   logic [KEY_W-1:0]  rsp_key_ff;

   logic                  accept;
   logic                  accept_snap;
   logic                  accept_pop;
   logic                  word_ok;
   logic                  empty;
   logic                  push;
   logic [PTR_W-1:0]      wr_next;
   logic [PTR_W-1:0]      rd_next;
   logic [WORD_SEL_W-1:0] word_sel;
   lane_hit_type          lanes [LANES];
   lane_hit_type          pick;
   logic [LANES-1:0]      pick_mask;

   // Handshake and decode of the request word.
   assign req.ready   = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign accept      = req.valid && req.ready;
   assign word_ok     = {1'b0, req.word_index} < (WORD_W + 1)'(BITMAP_WORDS);
   assign word_sel    = req.word_index[WORD_SEL_W-1:0];
   assign accept_snap = accept && (req.op == OP_SNAPSHOT) && word_ok;
   assign accept_pop  = accept && (req.op == OP_POP);

   // Queue pointer arithmetic; the ring keeps one slot free.
   assign empty   = (wr_ff == rd_ff);
   assign wr_next = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
   assign rd_next = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
   assign push    = (state_ff == ST_WALK) && pick.hit && (wr_next != rd_ff);

   // One lane per bit of the snapshot word.
   for (genvar b = 0; b < LANES; b++) begin : g_lane
      keq_lane u_lane (
         .word_sel   (word_ff),
         .lane_index (LANE_W'(b)),
         .changed    (pend_ff[b]),
         .now_bit    (now_ff[b]),
         .lane_out   (lanes[b])
      );
   end

   keq_merge u_merge (
      .lanes     (lanes),
      .pick      (pick),
      .pick_mask (pick_mask)
   );

   // Next-state logic of the sequencer, pointers and held bitmap.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_in        = wr_ff;
      rd_in        = rd_ff;
      pend_in      = pend_ff;
      now_in       = now_ff;
      word_in      = word_ff;
      prev_in      = prev_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept_snap) begin
               pend_in           = req.held_bits ^ prev_ff[word_sel];
               now_in            = req.held_bits;
               word_in           = req.word_index;
               prev_in[word_sel] = req.held_bits;
               state_in          = ST_WALK;
            end
         end
         ST_WALK: begin
            pend_in = pend_ff & ~pick_mask;
            if (push) begin
               wr_in = wr_next;
            end
            if (!pick.hit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept_pop) begin
         rsp_valid_in = 1'b1;
         if (!empty) begin
            rd_in = rd_next;
         end
      end
   end

   // State, pointers, walk registers, held bitmap and the response valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         wr_ff        <= '0;
         rd_ff        <= '0;
         pend_ff      <= '0;
         now_ff       <= '0;
         word_ff      <= '0;
         for (int i = 0; i < BITMAP_WORDS; i++) begin
            prev_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_ff        <= wr_in;
         rd_ff        <= rd_in;
         pend_ff      <= pend_in;
         now_ff       <= now_in;
         word_ff      <= word_in;
         prev_ff      <= prev_in;
      end
   end

   // Queue memory: one write per pushed event, registered read into the response word.
   always_ff @(posedge clock) begin
      if (push) begin
         event_store[wr_ff] <= {pick.pressed, pick.key_code};
      end
      if (accept_pop) begin
         rsp_event_valid_ff <= !empty;
         if (empty) begin
            rsp_pressed_ff <= 1'b0;
            rsp_key_ff     <= '0;
         end else begin
            {rsp_pressed_ff, rsp_key_ff} <= event_store[rd_ff];
         end
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.event_valid = rsp_event_valid_ff;
   assign rsp.pressed     = rsp_pressed_ff;
   assign rsp.key_code    = rsp_key_ff;

   // Every accepted pop produces a response word on the next cycle.
   a_pop_answers: assert property (@(posedge clock) disable iff (reset)
      accept_pop |=> rsp.valid)
      else $error("pop accepted without a response word");

   // A snapshot never creates a response word.
   a_snap_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && (req.op == OP_SNAPSHOT) && !rsp.valid) |=> !rsp.valid)
      else $error("snapshot produced a response word");

   // A non-empty queue only becomes empty through a pop, so pushes never overfill it.
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      (!accept_pop && (wr_ff != rd_ff)) |=> (wr_ff != rd_ff))
      else $error("queue wrapped onto its read pointer");

   // An empty-queue response carries an all-zero event.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.event_valid) |-> (!rsp.pressed && (rsp.key_code == '0)))
      else $error("empty response carries event data");

endmodule

`default_nettype wire
